/* rtl/abir_pkg.sv */
`default_nettype none

package abir_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_IDX = 2'd2;

    // register indexes
    localparam logic [1:0] REG_GRAVITY_X = 2'd0;
    localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
    localparam logic [1:0] REG_TIME_STEP = 2'd2;

    localparam int          PADDR_W       = 4;
    localparam logic [15:0] TIME_STEP_RST = 16'd1092;

    // width of the shared saturating adder
    localparam int ADD_W = 36;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [30:0] half_x;
        logic        [30:0] half_y;
        logic               is_static;
        logic        [15:0] bounce;
    } body_t;

    typedef struct packed {
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic        [15:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [5:0]  body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } res_t;

    typedef struct packed {
        logic signed [32:0]      mul_a;
        logic        [15:0]      mul_b;
        logic signed [ADD_W-1:0] add_a;
        logic signed [ADD_W-1:0] add_b;
        logic                    use_prod;
        logic                    prod_q15;
    } alu_req_t;

    function automatic logic signed [32:0] neg33(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return -w;
    endfunction

endpackage

`default_nettype wire

/* rtl/abir_if.sv */
`default_nettype none

interface abir_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic        [5:0]  index_a;
    logic        [5:0]  index_b;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic        [30:0] new_half_x;
    logic        [30:0] new_half_y;
    logic               new_is_static;
    logic        [15:0] new_restitution;

    modport source (
        output valid, cmd, index_a, index_b, new_pos_x, new_pos_y, new_vel_x,
               new_vel_y, new_half_x, new_half_y, new_is_static, new_restitution,
        input  ready
    );
    modport sink (
        input  valid, cmd, index_a, index_b, new_pos_x, new_pos_y, new_vel_x,
               new_vel_y, new_half_x, new_half_y, new_is_static, new_restitution,
        output ready
    );
endinterface

interface abir_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic        [5:0]  body_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;

    modport source (
        output valid, status, body_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
        input  ready
    );
    modport sink (
        input  valid, status, body_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/abir_ram.sv */
`default_nettype none

module abir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

/* rtl/abir_alu.sv */
`default_nettype none

module abir_alu (
    input  wire logic               clk,
    input  wire abir_pkg::alu_req_t op,
    output logic signed [31:0]      sum
);
    import abir_pkg::*;

    logic signed [49:0]      prod_full;
    logic signed [48:0]      prod_reg;
    logic signed [48:0]      prod_sh;
    logic signed [ADD_W-1:0] add_b;
    logic signed [ADD_W-1:0] total;

    assign prod_full = op.mul_a * $signed({1'b0, op.mul_b});

    // product register between the multiplier and the adder
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[48:0];
    end

    // arithmetic shift gives the floor rounding
    assign prod_sh = op.prod_q15 ? (prod_reg >>> 15) : (prod_reg >>> 16);
    assign add_b   = op.use_prod ? ADD_W'(prod_sh) : op.add_b;
    assign total   = op.add_a + add_b;

    always_comb
    begin
        if (total > ADD_W'(64'sh7FFFFFFF))
        begin
            sum = 32'sh7FFFFFFF;
        end
        else if (total < -ADD_W'(64'sh80000000))
        begin
            sum = 32'sh80000000;
        end
        else
        begin
            sum = total[31:0];
        end
    end
endmodule

`default_nettype wire

/* rtl/abir_cfg.sv */
`default_nettype none

module abir_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abir_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output abir_pkg::cfg_t                     cfg
);
    import abir_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_x <= '0;
            cfg_reg.gravity_y <= '0;
            cfg_reg.time_step <= TIME_STEP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GRAVITY_X: cfg_reg.gravity_x <= pwdata;
                REG_GRAVITY_Y: cfg_reg.gravity_y <= pwdata;
                REG_TIME_STEP: cfg_reg.time_step <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRAVITY_X: prdata = cfg_reg.gravity_x;
            REG_GRAVITY_Y: prdata = cfg_reg.gravity_y;
            REG_TIME_STEP: prdata = {16'd0, cfg_reg.time_step};
            default:       prdata = '0;
        endcase
    end
endmodule

`default_nettype wire

/* rtl/aabb_body_integrate_resolve.sv */
// Table of up to MAX_BODIES axis-aligned 2D bodies (Q16.16) with four requests: add,
// tick (Euler step of every moving body), resolve (push a colliding pair apart on the
// axis of least overlap and reflect velocities by restitution) and read. One request is
// processed at a time and the request channel is not ready meanwhile. Resolve ends early
// when an index is out of range or both indexes are the same, and again when the boxes
// do not overlap or both bodies are static. Tick reads every body in turn and skips the
// arithmetic for static bodies. Requests run as a sequence of steps because of the single
// read port of the body memory and one shared multiplier and saturating adder, which a
// small sequencer uses once per step. A finished result waits in an output register, so
// a new request can be taken while it is still pending; the last step of a request
// stalls only while that register holds an unaccepted result.
`default_nettype none

module aabb_body_integrate_resolve #(
    parameter int MAX_BODIES = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    abir_req_if.sink                          req,
    abir_rsp_if.source                        rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [abir_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import abir_pkg::*;

    localparam int AW   = $clog2(MAX_BODIES);
    localparam int CW   = $clog2(MAX_BODIES + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    typedef enum logic [22:0] {
        S_IDLE   = 23'h000001,
        S_TK_RD  = 23'h000002,
        S_TK_LD  = 23'h000004,
        S_TK_VX  = 23'h000008,
        S_TK_VY  = 23'h000010,
        S_TK_PX  = 23'h000020,
        S_TK_PY  = 23'h000040,
        S_TK_WB  = 23'h000080,
        S_RS_RA  = 23'h000100,
        S_RS_RB  = 23'h000200,
        S_RS_LB  = 23'h000400,
        S_RS_DIF = 23'h000800,
        S_RS_OVL = 23'h001000,
        S_RS_DEC = 23'h002000,
        S_RS_VA  = 23'h004000,
        S_RS_VB  = 23'h008000,
        S_RS_PA  = 23'h010000,
        S_RS_PB  = 23'h020000,
        S_RS_WA  = 23'h040000,
        S_RS_WB  = 23'h080000,
        S_RD_RD  = 23'h100000,
        S_RD_LD  = 23'h200000,
        S_FIN    = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [5:0]    ia_reg, ia_next;
    logic [5:0]    ib_reg, ib_next;
    logic          ovalid_reg, ovalid_next;
    res_t          out_reg, out_next;
    res_t          res_reg, res_next;
    body_t         ba_reg, ba_next;
    body_t         bb_reg, bb_next;
    logic [32:0]        adx_reg, adx_next;
    logic [32:0]        ady_reg, ady_next;
    logic [31:0]        hsx_reg, hsx_next;
    logic [31:0]        hsy_reg, hsy_next;
    logic signed [33:0] ox_reg, ox_next;
    logic signed [33:0] oy_reg, oy_next;
    logic signed [34:0] delta_reg, delta_next;
    logic               axis_x_reg, axis_x_next;

    cfg_t               cfg;
    alu_req_t           alu_op;
    logic signed [31:0] alu_sum;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    body_t              ram_wdata;
    body_t              ram_rdata;

    logic               sel_x;
    logic signed [31:0] pa_sel, pb_sel, va_sel, vb_sel;
    logic signed [32:0] dx, dy;
    logic signed [33:0] o_sel;
    logic signed [34:0] push;
    logic               bad_a, bad_b, full;

    abir_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    abir_alu u_alu (
        .clk (clk),
        .op  (alu_op),
        .sum (alu_sum)
    );

    abir_ram #(
        .WIDTH ($bits(body_t)),
        .DEPTH (MAX_BODIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.body_index = out_reg.body_index;
    assign rsp.out_pos_x  = out_reg.pos_x;
    assign rsp.out_pos_y  = out_reg.pos_y;
    assign rsp.out_vel_x  = out_reg.vel_x;
    assign rsp.out_vel_y  = out_reg.vel_y;

    assign full  = (count_reg >= CW'(MAX_BODIES));
    assign bad_a = (CMPW'(req.index_a) >= CMPW'(count_reg));
    assign bad_b = (CMPW'(req.index_b) >= CMPW'(count_reg));

    // axis is decided in the decision step and held afterwards
    assign sel_x  = (state_reg == S_RS_DEC) ? (ox_reg < oy_reg) : axis_x_reg;
    assign pa_sel = sel_x ? ba_reg.pos_x : ba_reg.pos_y;
    assign pb_sel = sel_x ? bb_reg.pos_x : bb_reg.pos_y;
    assign va_sel = sel_x ? ba_reg.vel_x : ba_reg.vel_y;
    assign vb_sel = sel_x ? bb_reg.vel_x : bb_reg.vel_y;
    assign dx     = 33'(ba_reg.pos_x) - 33'(bb_reg.pos_x);
    assign dy     = 33'(ba_reg.pos_y) - 33'(bb_reg.pos_y);
    assign o_sel  = sel_x ? ox_reg : oy_reg;
    // half split only when both bodies move
    assign push   = (!ba_reg.is_static && !bb_reg.is_static) ? 35'(o_sel >>> 1)
                                                             : 35'(o_sel);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        out_next    = out_reg;
        res_next    = res_reg;
        ba_next     = ba_reg;
        bb_next     = bb_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        hsx_next    = hsx_reg;
        hsy_next    = hsy_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        delta_next  = delta_reg;
        axis_x_next = axis_x_reg;
        alu_op      = '0;
        ram_we      = 1'b0;
        ram_waddr   = AW'(idx_reg);
        ram_wdata   = ba_reg;
        ram_raddr   = AW'(idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next = '0;
                    ia_next  = req.index_a;
                    ib_next  = req.index_b;
                    idx_next = '0;
                    unique case (req.cmd)
                        CMD_ADD:
                        begin
                            state_next = S_FIN;
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we              = 1'b1;
                                ram_waddr           = AW'(count_reg);
                                ram_wdata.pos_x     = req.new_pos_x;
                                ram_wdata.pos_y     = req.new_pos_y;
                                ram_wdata.vel_x     = req.new_vel_x;
                                ram_wdata.vel_y     = req.new_vel_y;
                                ram_wdata.half_x    = req.new_half_x;
                                ram_wdata.half_y    = req.new_half_y;
                                ram_wdata.is_static = req.new_is_static;
                                ram_wdata.bounce    = req.new_restitution;
                                res_next.body_index = 6'(count_reg);
                                count_next          = count_reg + CW'(1);
                            end
                        end
                        CMD_TICK:
                        begin
                            state_next = S_TK_RD;
                        end
                        CMD_RESOLVE:
                        begin
                            if (bad_a || bad_b)
                            begin
                                res_next.status = ST_BAD_IDX;
                                state_next      = S_FIN;
                            end
                            else if (req.index_a == req.index_b)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_RS_RA;
                            end
                        end
                        CMD_READ:
                        begin
                            res_next.body_index = req.index_a;
                            if (bad_a)
                            begin
                                res_next.status = ST_BAD_IDX;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                state_next = S_RD_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_TK_RD:
            begin
                state_next = (idx_reg >= count_reg) ? S_FIN : S_TK_LD;
            end
            S_TK_LD:
            begin
                ba_next = ram_rdata;
                if (ram_rdata.is_static)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_TK_RD;
                end
                else
                begin
                    alu_op.mul_a = 33'(cfg.gravity_x);
                    alu_op.mul_b = cfg.time_step;
                    state_next   = S_TK_VX;
                end
            end
            S_TK_VX:
            begin
                alu_op.add_a    = ADD_W'(ba_reg.vel_x);
                alu_op.use_prod = 1'b1;
                alu_op.mul_a    = 33'(cfg.gravity_y);
                alu_op.mul_b    = cfg.time_step;
                ba_next.vel_x   = alu_sum;
                state_next      = S_TK_VY;
            end
            S_TK_VY:
            begin
                alu_op.add_a    = ADD_W'(ba_reg.vel_y);
                alu_op.use_prod = 1'b1;
                alu_op.mul_a    = 33'(ba_reg.vel_x);
                alu_op.mul_b    = cfg.time_step;
                ba_next.vel_y   = alu_sum;
                state_next      = S_TK_PX;
            end
            S_TK_PX:
            begin
                alu_op.add_a    = ADD_W'(ba_reg.pos_x);
                alu_op.use_prod = 1'b1;
                alu_op.mul_a    = 33'(ba_reg.vel_y);
                alu_op.mul_b    = cfg.time_step;
                ba_next.pos_x   = alu_sum;
                state_next      = S_TK_PY;
            end
            S_TK_PY:
            begin
                alu_op.add_a    = ADD_W'(ba_reg.pos_y);
                alu_op.use_prod = 1'b1;
                ba_next.pos_y   = alu_sum;
                state_next      = S_TK_WB;
            end
            S_TK_WB:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = S_TK_RD;
            end

            S_RS_RA:
            begin
                ram_raddr  = AW'(ia_reg);
                state_next = S_RS_RB;
            end
            S_RS_RB:
            begin
                ram_raddr  = AW'(ib_reg);
                ba_next    = ram_rdata;
                state_next = S_RS_LB;
            end
            S_RS_LB:
            begin
                bb_next    = ram_rdata;
                state_next = S_RS_DIF;
            end
            S_RS_DIF:
            begin
                adx_next   = dx[32] ? 33'(-dx) : 33'(dx);
                ady_next   = dy[32] ? 33'(-dy) : 33'(dy);
                hsx_next   = 32'(ba_reg.half_x) + 32'(bb_reg.half_x);
                hsy_next   = 32'(ba_reg.half_y) + 32'(bb_reg.half_y);
                state_next = S_RS_OVL;
            end
            S_RS_OVL:
            begin
                ox_next    = $signed({2'b00, hsx_reg}) - $signed({1'b0, adx_reg});
                oy_next    = $signed({2'b00, hsy_reg}) - $signed({1'b0, ady_reg});
                state_next = S_RS_DEC;
            end
            S_RS_DEC:
            begin
                if ((ba_reg.is_static && bb_reg.is_static) || ox_reg <= 34'sd0
                    || oy_reg <= 34'sd0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    axis_x_next  = sel_x;
                    delta_next   = (pa_sel < pb_sel) ? -push : push;
                    alu_op.mul_a = neg33(va_sel);
                    alu_op.mul_b = ba_reg.bounce;
                    state_next   = S_RS_VA;
                end
            end
            S_RS_VA:
            begin
                alu_op.use_prod = 1'b1;
                alu_op.prod_q15 = 1'b1;
                alu_op.mul_a    = neg33(vb_sel);
                alu_op.mul_b    = bb_reg.bounce;
                if (!ba_reg.is_static)
                begin
                    if (axis_x_reg)
                    begin
                        ba_next.vel_x = alu_sum;
                    end
                    else
                    begin
                        ba_next.vel_y = alu_sum;
                    end
                end
                state_next = S_RS_VB;
            end
            S_RS_VB:
            begin
                alu_op.use_prod = 1'b1;
                alu_op.prod_q15 = 1'b1;
                if (!bb_reg.is_static)
                begin
                    if (axis_x_reg)
                    begin
                        bb_next.vel_x = alu_sum;
                    end
                    else
                    begin
                        bb_next.vel_y = alu_sum;
                    end
                end
                state_next = S_RS_PA;
            end
            S_RS_PA:
            begin
                alu_op.add_a = ADD_W'(pa_sel);
                alu_op.add_b = ADD_W'(delta_reg);
                if (!ba_reg.is_static)
                begin
                    if (axis_x_reg)
                    begin
                        ba_next.pos_x = alu_sum;
                    end
                    else
                    begin
                        ba_next.pos_y = alu_sum;
                    end
                end
                state_next = S_RS_PB;
            end
            S_RS_PB:
            begin
                alu_op.add_a = ADD_W'(pb_sel);
                alu_op.add_b = -ADD_W'(delta_reg);
                if (!bb_reg.is_static)
                begin
                    if (axis_x_reg)
                    begin
                        bb_next.pos_x = alu_sum;
                    end
                    else
                    begin
                        bb_next.pos_y = alu_sum;
                    end
                end
                state_next = S_RS_WA;
            end
            S_RS_WA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(ia_reg);
                state_next = S_RS_WB;
            end
            S_RS_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(ib_reg);
                ram_wdata  = bb_reg;
                state_next = S_FIN;
            end

            S_RD_RD:
            begin
                ram_raddr  = AW'(ia_reg);
                state_next = S_RD_LD;
            end
            S_RD_LD:
            begin
                res_next.pos_x = ram_rdata.pos_x;
                res_next.pos_y = ram_rdata.pos_y;
                res_next.vel_x = ram_rdata.vel_x;
                res_next.vel_y = ram_rdata.vel_y;
                state_next     = S_FIN;
            end

            S_FIN:
            begin
                // hand over once the output register is free
                if (!ovalid_reg || rsp.ready)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg     <= ia_next;
        ib_reg     <= ib_next;
        out_reg    <= out_next;
        res_reg    <= res_next;
        ba_reg     <= ba_next;
        bb_reg     <= bb_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        hsx_reg    <= hsx_next;
        hsy_reg    <= hsy_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        delta_reg  <= delta_next;
        axis_x_reg <= axis_x_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BODIES))
        else $error("body count above table size");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.cmd == CMD_ADD && !full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("add did not grow the table");

    a_tick_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TK_LD |-> idx_reg < count_reg)
        else $error("tick visits a body beyond the table");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && ovalid_reg && !rsp.ready |=> state_reg == S_FIN)
        else $error("pending result overwritten");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("request taken while busy");
endmodule

`default_nettype wire
